// ===== rtl/rwbl_pkg.sv =====
package rwbl_pkg;

    localparam int BLK_W = 48;
    localparam int LSN_W = 48;
    localparam int SEG_W = 32;
    localparam int OFF_W = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BUSY      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_DRAIN,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [BLK_W-1:0] start_block;
        logic [BLK_W-1:0] end_block;
        logic [LSN_W-1:0] log_seq;
        logic [SEG_W-1:0] seg_in;
        logic [OFF_W-1:0] offset_in;
        logic [BLK_W-1:0] limit_in;
    } cmd_t;

    typedef struct packed {
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic [BLK_W-1:0] start_block;
        logic [BLK_W-1:0] end_block;
        logic [LSN_W-1:0] lsn;
        logic [SEG_W-1:0] seg;
        logic [OFF_W-1:0] offset;
    } entry_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  range_start;
        logic [BLK_W-1:0]  range_limit;
        logic [SEG_W-1:0]  seg_out;
        logic [OFF_W-1:0]  offset_out;
        logic [LSN_W-1:0]  lsn_out;
    } rsp_t;

endpackage

// ===== rtl/rwbl_req_if.sv =====
interface rwbl_req_if;
    import rwbl_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  start_block;
    logic [BLK_W-1:0]  end_block;
    logic [LSN_W-1:0]  log_seq;
    logic [SEG_W-1:0]  seg_in;
    logic [OFF_W-1:0]  offset_in;
    logic [BLK_W-1:0]  limit_in;

    modport source (output valid, func, start_block, end_block, log_seq, seg_in,
                    offset_in, limit_in, input ready);
    modport sink (input valid, func, start_block, end_block, log_seq, seg_in,
                  offset_in, limit_in, output ready);
endinterface

// ===== rtl/rwbl_rsp_if.sv =====
interface rwbl_rsp_if;
    import rwbl_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  range_start;
    logic [BLK_W-1:0]  range_limit;
    logic [SEG_W-1:0]  seg_out;
    logic [OFF_W-1:0]  offset_out;
    logic [LSN_W-1:0]  lsn_out;

    modport source (output valid, status, range_start, range_limit, seg_out,
                    offset_out, lsn_out, input ready);
    modport sink (input valid, status, range_start, range_limit, seg_out,
                  offset_out, lsn_out, output ready);
endinterface

// ===== rtl/rwbl_front.sv =====
module rwbl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rwbl_req_if.sink             req,
    input  rwbl_pkg::queue_ctl_t ctl_in,
    output logic                 q_valid,
    output rwbl_pkg::cmd_t       q_cmd
);
    import rwbl_pkg::*;

    localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t            fifo_reg [QUEUE_DEPTH];
    logic [QI_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QI_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            push;
    cmd_t            cmd_new;

    // classify the function code
    always_comb
    begin
        cmd_new.start_block = req.start_block;
        cmd_new.end_block   = req.end_block;
        cmd_new.log_seq     = req.log_seq;
        cmd_new.seg_in      = req.seg_in;
        cmd_new.offset_in   = req.offset_in;
        cmd_new.limit_in    = req.limit_in;
        unique case (req.func)
            FUNC_INSERT: cmd_new.op = OP_INSERT;
            FUNC_LOOKUP: cmd_new.op = OP_LOOKUP;
            FUNC_DRAIN:  cmd_new.op = OP_DRAIN;
            default:     cmd_new.op = OP_NONE;
        endcase
    end

    assign req.ready = (count_reg != QC_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QI_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctl_in.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QI_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !ctl_in.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && ctl_in.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

// ===== rtl/rwbl_back.sv =====
module rwbl_back #(
    parameter int RING_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rwbl_pkg::cmd_t       q_cmd,
    output rwbl_pkg::queue_ctl_t ctl_out,
    rwbl_rsp_if.source           rsp
);
    import rwbl_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int PW = AW + 1;
    localparam logic [PW:0]   TWO_D = (PW + 1)'(2 * RING_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
    localparam logic [PW-1:0] LAST_P = PW'(2 * RING_DEPTH - 1);

    function automatic logic [PW-1:0] pos_prev(input logic [PW-1:0] p);
        return (p == '0) ? LAST_P : p - 1'b1;
    endfunction

    function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
        return (p == LAST_P) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return s[AW-1:0];
    endfunction

    entry_t mem [RING_DEPTH];
    entry_t rd_data_reg;
    entry_t wr_entry;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    state_t        state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] left_reg, left_next;
    logic [BLK_W-1:0] sb_reg, sb_next;
    logic [BLK_W-1:0] ended_reg, ended_next;
    logic [BLK_W-1:0] limit_reg, limit_next;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [PW:0]   occ_wrap;
    logic [PW-1:0] occ;
    logic          full, empty, start;
    logic          ends_before, starts_after, hit, last;
    logic [BLK_W-1:0] eff_start, lim_min, clip;
    logic [BLK_W-1:0] ended_upd, limit_upd;

    assign occ_wrap = {1'b0, head_reg} + TWO_D - {1'b0, tail_reg};
    assign occ      = (head_reg >= tail_reg) ? head_reg - tail_reg : occ_wrap[PW-1:0];
    assign full     = (occ >= DEPTH_P);
    assign empty    = (occ == '0);
    assign start    = (state_reg == ST_IDLE) && q_valid && !rsp_valid_reg;

    assign ctl_out.pop = start;

    // one entry of the newest-to-oldest walk
    assign ends_before  = (rd_data_reg.end_block <= sb_reg);
    assign starts_after = (sb_reg < rd_data_reg.start_block);
    assign hit          = !ends_before && !starts_after;
    assign last         = (left_reg == PW'(1));
    assign ended_upd    = (ends_before && rd_data_reg.end_block > ended_reg) ?
                          rd_data_reg.end_block : ended_reg;
    assign limit_upd    = (!ends_before && starts_after && rd_data_reg.start_block < limit_reg) ?
                          rd_data_reg.start_block : limit_reg;
    assign eff_start    = (ended_reg > rd_data_reg.start_block) ? ended_reg
                                                                : rd_data_reg.start_block;
    assign clip         = eff_start - rd_data_reg.start_block;
    assign lim_min      = (rd_data_reg.end_block < limit_reg) ? rd_data_reg.end_block : limit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && q_cmd.op == OP_DRAIN && !empty)
                begin
                    state_next = ST_DRAIN;
                end
                else if (start && q_cmd.op == OP_LOOKUP && !empty)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (hit || last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        sb_next        = sb_reg;
        ended_next     = ended_reg;
        limit_next     = limit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        wr_en          = 1'b0;
        rd_addr        = slot_of(ptr_reg);
        wr_entry.start_block = q_cmd.start_block;
        wr_entry.end_block   = q_cmd.end_block;
        wr_entry.lsn         = q_cmd.log_seq;
        wr_entry.seg         = q_cmd.seg_in;
        wr_entry.offset      = q_cmd.offset_in;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rsp_next = '0;
                    unique case (q_cmd.op)
                        OP_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = STAT_BUSY;
                            end
                            else
                            begin
                                rsp_next.status = STAT_OK;
                                wr_en           = 1'b1;
                                head_next       = pos_next(head_reg);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            sb_next    = q_cmd.start_block;
                            limit_next = q_cmd.limit_in;
                            ended_next = '0;
                            rd_addr    = slot_of(pos_prev(head_reg));
                            ptr_next   = pos_prev(pos_prev(head_reg));
                            left_next  = occ;
                            if (empty)
                            begin
                                rsp_valid_next       = 1'b1;
                                rsp_next.status      = STAT_NOT_FOUND;
                                rsp_next.range_limit = q_cmd.limit_in;
                            end
                        end
                        OP_DRAIN:
                        begin
                            rd_addr = slot_of(tail_reg);
                            if (empty)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                ended_next = ended_upd;
                limit_next = limit_upd;
                if (hit)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = STAT_OK;
                    rsp_next.range_start = eff_start;
                    rsp_next.range_limit = lim_min;
                    rsp_next.seg_out     = rd_data_reg.seg;
                    rsp_next.offset_out  = rd_data_reg.offset + clip[OFF_W-1:0];
                    rsp_next.lsn_out     = '0;
                end
                else if (last)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.status      = STAT_NOT_FOUND;
                    rsp_next.range_limit = limit_upd;
                end
                else
                begin
                    rd_addr   = slot_of(ptr_reg);
                    ptr_next  = pos_prev(ptr_reg);
                    left_next = left_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.status      = STAT_OK;
                rsp_next.range_start = rd_data_reg.start_block;
                rsp_next.range_limit = rd_data_reg.end_block;
                rsp_next.seg_out     = rd_data_reg.seg;
                rsp_next.offset_out  = rd_data_reg.offset;
                rsp_next.lsn_out     = rd_data_reg.lsn;
                tail_next            = pos_next(tail_reg);
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            left_reg      <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            left_reg      <= left_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg    <= sb_next;
        ended_reg <= ended_next;
        limit_reg <= limit_next;
        rsp_reg   <= rsp_next;
    end

    // ring storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_of(head_reg)] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_reg.status;
    assign rsp.range_start = rsp_reg.range_start;
    assign rsp.range_limit = rsp_reg.range_limit;
    assign rsp.seg_out     = rsp_reg.seg_out;
    assign rsp.offset_out  = rsp_reg.offset_out;
    assign rsp.lsn_out     = rsp_reg.lsn_out;

endmodule

// ===== rtl/range_write_buffer_lookup_top.sv =====
// channel | dir | handshake   | payload
// req     | in  | valid/ready | func, start_block, end_block, log_seq, seg_in,
//         |     |             | offset_in, limit_in
// rsp     | out | valid/ready | status, range_start, range_limit, seg_out,
//         |     |             | offset_out, lsn_out
//
// insert and unused codes are answered from the idle state, drain reads the
// oldest entry and answers from the drain state, lookup walks up to RING_DEPTH
// entries, one ring read per cycle through the single read port
// a two-deep request queue keeps taking requests while the back end works
// or while a response waits; rsp stalls hold the back end before its next request
// reset clears the queue, ring pointers and response valid, ring data is not cleared
module range_write_buffer_lookup_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    rwbl_req_if.sink   req,
    rwbl_rsp_if.source rsp
);
    import rwbl_pkg::*;

    // queue handshake between front and back
    queue_ctl_t ctl;
    logic       q_valid;
    cmd_t       q_cmd;

    // front: classify and buffer requests
    rwbl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .ctl_in  (ctl),
        .q_valid (q_valid),
        .q_cmd   (q_cmd)
    );

    // back: ring storage, walk sequencer and response register
    rwbl_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .ctl_out (ctl),
        .rsp     (rsp)
    );

endmodule
